[design/spot_pkg.sv]
// ----------------------------------------------------------------------------
// spot_pkg
// Shared types and widths for the shape pair overlap test.
// ----------------------------------------------------------------------------
package spot_pkg;

    localparam int COORD_BITS = 16;
    localparam int OPND_BITS  = COORD_BITS + 1;
    localparam int DIFF_BITS  = COORD_BITS + 3;

    typedef enum logic [1:0] {
        TEST_CC = 2'd0,
        TEST_RR = 2'd1,
        TEST_CR = 2'd2
    } t_test;

    typedef struct packed {
        logic                         kind_a;
        logic signed [COORD_BITS-1:0] pos_ax;
        logic signed [COORD_BITS-1:0] pos_ay;
        logic        [COORD_BITS-1:0] size_aw;
        logic        [COORD_BITS-1:0] size_ah;
        logic                         live_a;
        logic                         kind_b;
        logic signed [COORD_BITS-1:0] pos_bx;
        logic signed [COORD_BITS-1:0] pos_by;
        logic        [COORD_BITS-1:0] size_bw;
        logic        [COORD_BITS-1:0] size_bh;
        logic                         live_b;
    } t_in;

    typedef struct packed {
        logic  hit;
        t_test test_used;
    } t_out;

    typedef struct packed {
        t_test                test;
        logic                 decided;
        logic                 hit;
        logic [OPND_BITS-1:0] u;
        logic [OPND_BITS-1:0] v;
        logic [OPND_BITS-1:0] r;
    } t_prep;

endpackage

[design/spot_prep.sv]
// ----------------------------------------------------------------------------
// spot_prep
// Selects the test, settles the rectangle pair and the early decisions of the
// circle-rectangle test, and forms the operands of the distance compare.
// ----------------------------------------------------------------------------
module spot_prep
    import spot_pkg::*;
(
    input  t_in   i_item,
    output t_prep o_prep
);

    logic signed [DIFF_BITS-1:0] ax_e, ay_e, bx_e, by_e;
    logic signed [DIFF_BITS-1:0] ddx, ddy;
    logic        [DIFF_BITS-1:0] cc_dx, cc_dy;
    logic        [OPND_BITS-1:0] r_sum;
    logic                        rr_hit;
    logic signed [DIFF_BITS-1:0] cx_e, cy_e, rx_e, ry_e;
    logic        [COORD_BITS-1:0] c_r, rw, rh;
    logic        [DIFF_BITS-1:0] w_e, h_e, r2_e;
    logic signed [DIFF_BITS-1:0] cdx, cdy;
    logic        [DIFF_BITS-1:0] mdx, mdy, ex_u, ex_v;
    logic                        reject, band;

    always_comb begin
        ax_e = DIFF_BITS'(i_item.pos_ax);
        ay_e = DIFF_BITS'(i_item.pos_ay);
        bx_e = DIFF_BITS'(i_item.pos_bx);
        by_e = DIFF_BITS'(i_item.pos_by);

        ddx   = ax_e - bx_e;
        ddy   = ay_e - by_e;
        cc_dx = ddx[DIFF_BITS-1] ? DIFF_BITS'(-ddx) : DIFF_BITS'(ddx);
        cc_dy = ddy[DIFF_BITS-1] ? DIFF_BITS'(-ddy) : DIFF_BITS'(ddy);
        r_sum = OPND_BITS'(i_item.size_aw) + OPND_BITS'(i_item.size_bw);

        rr_hit = (ax_e <= bx_e + $signed(DIFF_BITS'(i_item.size_bw)))
              && (ax_e + $signed(DIFF_BITS'(i_item.size_aw)) >= bx_e)
              && (ay_e <= by_e + $signed(DIFF_BITS'(i_item.size_bh)))
              && (ay_e + $signed(DIFF_BITS'(i_item.size_ah)) >= by_e)
              && i_item.live_a && i_item.live_b;

        if (i_item.kind_a) begin
            cx_e = bx_e;
            cy_e = by_e;
            c_r  = i_item.size_bw;
            rx_e = ax_e;
            ry_e = ay_e;
            rw   = i_item.size_aw;
            rh   = i_item.size_ah;
        end else begin
            cx_e = ax_e;
            cy_e = ay_e;
            c_r  = i_item.size_aw;
            rx_e = bx_e;
            ry_e = by_e;
            rw   = i_item.size_bw;
            rh   = i_item.size_bh;
        end

        w_e  = DIFF_BITS'(rw);
        h_e  = DIFF_BITS'(rh);
        r2_e = DIFF_BITS'({c_r, 1'b0});
        cdx  = (cx_e <<< 1) - ((rx_e <<< 1) + $signed(w_e));
        cdy  = (cy_e <<< 1) - ((ry_e <<< 1) + $signed(h_e));
        mdx  = cdx[DIFF_BITS-1] ? DIFF_BITS'(-cdx) : DIFF_BITS'(cdx);
        mdy  = cdy[DIFF_BITS-1] ? DIFF_BITS'(-cdy) : DIFF_BITS'(cdy);
        ex_u = mdx - w_e;
        ex_v = mdy - h_e;

        reject = (mdx > w_e + r2_e) || (mdy > h_e + r2_e);
        band   = (mdx <= w_e) || (mdy <= h_e);

        o_prep = '0;
        if (!i_item.kind_a && !i_item.kind_b) begin
            o_prep.test    = TEST_CC;
            o_prep.decided = 1'b0;
            o_prep.hit     = 1'b0;
            o_prep.u       = cc_dx[OPND_BITS-1:0];
            o_prep.v       = cc_dy[OPND_BITS-1:0];
            o_prep.r       = r_sum;
        end else if (i_item.kind_a && i_item.kind_b) begin
            o_prep.test    = TEST_RR;
            o_prep.decided = 1'b1;
            o_prep.hit     = rr_hit;
        end else begin
            o_prep.test    = TEST_CR;
            o_prep.decided = reject || band;
            o_prep.hit     = !reject && band;
            o_prep.u       = ex_u[OPND_BITS-1:0];
            o_prep.v       = ex_v[OPND_BITS-1:0];
            o_prep.r       = r2_e[OPND_BITS-1:0];
        end
    end

endmodule

[design/spot_dist.sv]
// ----------------------------------------------------------------------------
// spot_dist
// Squared distance compare, u*u + v*v <= r*r, and the final verdict.
// ----------------------------------------------------------------------------
module spot_dist
    import spot_pkg::*;
(
    input  t_prep i_prep,
    output t_out  o_res
);

    localparam int SQ_BITS = 2 * OPND_BITS;

    logic [SQ_BITS-1:0] u_e, v_e, r_e;
    logic [SQ_BITS-1:0] sq_u, sq_v, sq_r;
    logic [SQ_BITS:0]   sq_sum;

    always_comb begin
        u_e    = SQ_BITS'(i_prep.u);
        v_e    = SQ_BITS'(i_prep.v);
        r_e    = SQ_BITS'(i_prep.r);
        sq_u   = u_e * u_e;
        sq_v   = v_e * v_e;
        sq_r   = r_e * r_e;
        sq_sum = (SQ_BITS + 1)'(sq_u) + (SQ_BITS + 1)'(sq_v);

        o_res.test_used = i_prep.test;
        o_res.hit       = i_prep.decided ? i_prep.hit
                                         : (sq_sum <= (SQ_BITS + 1)'(sq_r));
    end

endmodule

[design/shape_pair_overlap_test_top.sv]
// ----------------------------------------------------------------------------
// shape_pair_overlap_test_top
// Overlap test for one pair of circles or rectangles per transaction.
// ----------------------------------------------------------------------------
// Each transaction is registered in the input, operand and result registers in turn.
// Throughput: one transaction per cycle unless the result is held by i_out_ready low;
// the squared-distance multipliers set the critical path.
// Reset clears the valid flags of all three stages; no other state is kept.
// ----------------------------------------------------------------------------
module shape_pair_overlap_test_top
    import spot_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    logic  r_in_v, n_in_v;
    t_in   r_in, n_in;
    logic  r_mid_v, n_mid_v;
    t_prep r_mid, n_mid;
    logic  r_out_v, n_out_v;
    t_out  r_out, n_out;

    logic  out_ld, mid_ld, in_ld;
    t_prep prep;
    t_out  res;

    spot_prep u_prep (
        .i_item (r_in),
        .o_prep (prep)
    );

    spot_dist u_dist (
        .i_prep (r_mid),
        .o_res  (res)
    );

    always_comb begin
        out_ld = !r_out_v || i_out_ready;
        mid_ld = !r_mid_v || out_ld;
        in_ld  = !r_in_v || mid_ld;

        n_in_v  = in_ld ? i_in_valid : r_in_v;
        n_in    = (in_ld && i_in_valid) ? i_in : r_in;
        n_mid_v = mid_ld ? r_in_v : r_mid_v;
        n_mid   = (mid_ld && r_in_v) ? prep : r_mid;
        n_out_v = out_ld ? r_mid_v : r_out_v;
        n_out   = (out_ld && r_mid_v) ? res : r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_mid_v <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_in_v  <= n_in_v;
            r_mid_v <= n_mid_v;
            r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in  <= n_in;
        r_mid <= n_mid;
        r_out <= n_out;
    end

    assign o_in_ready  = in_ld;
    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

`ifndef NO_ASSERTIONS
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_v && r_mid_v && r_out_v && !i_out_ready) |-> !o_in_ready)
        else $error("transaction accepted while the pipeline is full");

    a_rr_decided: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mid_v && r_mid.test == TEST_RR) |-> r_mid.decided)
        else $error("rectangle pair sent to distance compare");

    a_cc_distance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mid_v && r_mid.test == TEST_CC) |-> !r_mid.decided)
        else $error("circle pair skipped distance compare");

    a_moves_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mid_v && out_ld) |=> o_out_valid)
        else $error("operand stage lost a transaction");
`endif

endmodule

[test/spot_overlap_checker.sv]
// ----------------------------------------------------------------------------
// spot_overlap_checker
// Watches both channels of the shape pair overlap test, works out the
// expected result of every accepted pair and compares each accepted result,
// field by field, with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module spot_overlap_checker
    import spot_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  t_in  i_in,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  t_out i_out,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    t_out expected_overlaps[$];

    function automatic longint span(input longint a, input longint b);
        return (a >= b) ? a - b : b - a;
    endfunction

    // True when u^2 + v^2 <= r^2, squares formed wide enough never to wrap.
    function automatic bit within_reach(input longint u, input longint v, input longint r);
        logic [127:0] wu;
        logic [127:0] wv;
        logic [127:0] wr;
        wu = 128'($unsigned(u));
        wv = 128'($unsigned(v));
        wr = 128'($unsigned(r));
        return (wu * wu + wv * wv) <= (wr * wr);
    endfunction

    function automatic bit circle_meets_rect(input longint cx, input longint cy,
                                             input longint r, input longint rx,
                                             input longint ry, input longint w,
                                             input longint h);
        longint dx;
        longint dy;
        dx = span(2 * cx, 2 * rx + w);
        dy = span(2 * cy, 2 * ry + h);
        if (dx > w + 2 * r || dy > h + 2 * r) begin
            return 1'b0;
        end
        if (dx <= w || dy <= h) begin
            return 1'b1;
        end
        return within_reach(dx - w, dy - h, 2 * r);
    endfunction

    function automatic t_out predict_overlap(input t_in x);
        t_out   res;
        longint ax;
        longint ay;
        longint aw;
        longint ah;
        longint bx;
        longint by;
        longint bw;
        longint bh;
        ax = longint'($signed(x.pos_ax));
        ay = longint'($signed(x.pos_ay));
        aw = longint'(x.size_aw);
        ah = longint'(x.size_ah);
        bx = longint'($signed(x.pos_bx));
        by = longint'($signed(x.pos_by));
        bw = longint'(x.size_bw);
        bh = longint'(x.size_bh);
        case ({x.kind_a, x.kind_b})
            2'b00: begin
                res.test_used = TEST_CC;
                res.hit = within_reach(span(ax, bx), span(ay, by), aw + bw);
            end
            2'b11: begin
                res.test_used = TEST_RR;
                res.hit = (ax <= bx + bw) && (ax + aw >= bx) && (ay <= by + bh)
                          && (ay + ah >= by) && x.live_a && x.live_b;
            end
            2'b01: begin
                res.test_used = TEST_CR;
                res.hit = circle_meets_rect(ax, ay, aw, bx, by, bw, bh);
            end
            default: begin
                res.test_used = TEST_CR;
                res.hit = circle_meets_rect(bx, by, bw, ax, ay, aw, ah);
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        o_fail_count++;
        $display("check: %s at %0t", msg, $time);
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (expected_overlaps.size() == 0) begin
                    report_mismatch($sformatf("result hit=%b test=%0d with none outstanding",
                                              i_out.hit, i_out.test_used));
                end else begin
                    want = expected_overlaps.pop_front();
                    if (i_out.hit !== want.hit) begin
                        report_mismatch($sformatf("hit got %b expected %b",
                                                  i_out.hit, want.hit));
                    end
                    if (i_out.test_used !== want.test_used) begin
                        report_mismatch($sformatf("test_used got %0d expected %0d",
                                                  i_out.test_used, want.test_used));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_overlaps.insert(expected_overlaps.size(), predict_overlap(i_in));
            end
        end
        o_pending = expected_overlaps.size();
    end

endmodule

[test/shape_pair_overlap_test_top_tb.sv]
// ----------------------------------------------------------------------------
// shape_pair_overlap_test_top_tb
// Drives directed and random shape pairs into the overlap test under three
// mixes of handshake idling, with full drains between them, and gives the
// verdict from the failure count of the checker.
// ----------------------------------------------------------------------------
module shape_pair_overlap_test_top_tb;
    import spot_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in        = '0;
    logic i_out_ready = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out;

    int fail_count;
    int pending;
    int unsigned send_idle_pct = 26;
    int unsigned recv_idle_pct = 54;
    int unsigned quiet_cycles  = 0;
    int cc_count = 0;
    int rr_count = 0;
    int cr_count = 0;

    shape_pair_overlap_test_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    spot_overlap_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in         (i_in),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out        (o_out),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #10 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_pair(input t_in x);
        case ({x.kind_a, x.kind_b})
            2'b00:   cc_count++;
            2'b11:   rr_count++;
            default: cr_count++;
        endcase
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= x;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_shapes(input bit ka, input int ax, input int ay,
                               input int unsigned aw, input int unsigned ah, input bit la,
                               input bit kb, input int bx, input int by,
                               input int unsigned bw, input int unsigned bh, input bit lb);
        t_in p;
        p.kind_a  = ka;
        p.pos_ax  = COORD_BITS'(ax);
        p.pos_ay  = COORD_BITS'(ay);
        p.size_aw = COORD_BITS'(aw);
        p.size_ah = COORD_BITS'(ah);
        p.live_a  = la;
        p.kind_b  = kb;
        p.pos_bx  = COORD_BITS'(bx);
        p.pos_by  = COORD_BITS'(by);
        p.size_bw = COORD_BITS'(bw);
        p.size_bh = COORD_BITS'(bh);
        p.live_b  = lb;
        send_pair(p);
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic run_random_phase(input int count);
        t_in p;
        int unsigned style;
        int unsigned lim;
        int unsigned off_x;
        int unsigned off_y;
        logic signed [COORD_BITS-1:0] base_x;
        logic signed [COORD_BITS-1:0] base_y;
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic [COORD_BITS-1:0] w;
        logic [COORD_BITS-1:0] h;
        logic [COORD_BITS-1:0] r;
        repeat (count) begin
            p.kind_a  = 1'($urandom_range(1));
            p.pos_ax  = COORD_BITS'($urandom);
            p.pos_ay  = COORD_BITS'($urandom);
            p.size_aw = COORD_BITS'($urandom);
            p.size_ah = COORD_BITS'($urandom);
            p.live_a  = 1'($urandom_range(1));
            p.kind_b  = 1'($urandom_range(1));
            p.pos_bx  = COORD_BITS'($urandom);
            p.pos_by  = COORD_BITS'($urandom);
            p.size_bw = COORD_BITS'($urandom);
            p.size_bh = COORD_BITS'($urandom);
            p.live_b  = 1'($urandom_range(1));
            style  = $urandom_range(99);
            base_x = COORD_BITS'($urandom);
            base_y = COORD_BITS'($urandom);
            case ($urandom_range(2))
                0:       lim = 4;
                1:       lim = 40;
                default: lim = 400;
            endcase
            if (style >= 20) begin
                p.live_a = ($urandom_range(9) != 0);
                p.live_b = ($urandom_range(9) != 0);
            end
            if (style >= 20 && style < 45) begin
                // A circle centred at or just beyond a corner of a rectangle.
                w     = COORD_BITS'($urandom_range(lim));
                h     = COORD_BITS'($urandom_range(lim));
                r     = COORD_BITS'($urandom_range(lim, 1));
                off_x = $urandom_range(r + 2);
                off_y = $urandom_range(r + 2);
                cx = ($urandom_range(1) == 0) ? base_x - COORD_BITS'(off_x)
                                              : base_x + w + COORD_BITS'(off_x);
                cy = ($urandom_range(1) == 0) ? base_y - COORD_BITS'(off_y)
                                              : base_y + h + COORD_BITS'(off_y);
                if ($urandom_range(1) == 0) begin
                    p.kind_a  = 1'b0;
                    p.pos_ax  = cx;
                    p.pos_ay  = cy;
                    p.size_aw = r;
                    p.kind_b  = 1'b1;
                    p.pos_bx  = base_x;
                    p.pos_by  = base_y;
                    p.size_bw = w;
                    p.size_bh = h;
                end else begin
                    p.kind_a  = 1'b1;
                    p.pos_ax  = base_x;
                    p.pos_ay  = base_y;
                    p.size_aw = w;
                    p.size_ah = h;
                    p.kind_b  = 1'b0;
                    p.pos_bx  = cx;
                    p.pos_by  = cy;
                    p.size_bw = r;
                end
            end else if (style >= 45) begin
                p.pos_ax  = base_x + COORD_BITS'($urandom_range(lim));
                p.pos_ay  = base_y + COORD_BITS'($urandom_range(lim));
                p.size_aw = COORD_BITS'($urandom_range(lim));
                p.size_ah = COORD_BITS'($urandom_range(lim));
                p.pos_bx  = base_x + COORD_BITS'($urandom_range(lim));
                p.pos_by  = base_y + COORD_BITS'($urandom_range(lim));
                p.size_bw = COORD_BITS'($urandom_range(lim));
                p.size_bh = COORD_BITS'($urandom_range(lim));
            end
            send_pair(p);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Circle pairs: touching points, exact tangency, near miss, extremes.
        send_shapes(0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 1);
        send_shapes(0, 0, 0, 2, 0, 1, 0, 3, 4, 3, 0, 1);
        send_shapes(0, 0, 0, 2, 0, 0, 0, 3, 4, 2, 0, 0);
        send_shapes(0, -32768, -32768, 65535, 65535, 0, 0, 32767, 32767, 65535, 65535, 1);
        send_shapes(0, -32768, -32768, 0, 0, 1, 0, 32767, 32767, 0, 0, 1);
        send_shapes(0, 5, 5, 1, 65535, 0, 0, 7, 5, 1, 65535, 0);
        // Rectangle pairs: shared corner, gap, inactive owners, extremes, points.
        send_shapes(1, 0, 0, 10, 10, 1, 1, 10, 10, 5, 5, 1);
        send_shapes(1, 0, 0, 10, 10, 1, 1, 11, 0, 5, 5, 1);
        send_shapes(1, 0, 0, 10, 10, 0, 1, 2, 2, 5, 5, 1);
        send_shapes(1, 0, 0, 10, 10, 1, 1, 2, 2, 5, 5, 0);
        send_shapes(1, 32767, 32767, 65535, 65535, 1, 1, -32768, -32768, 65535, 65535, 1);
        send_shapes(1, 3, 3, 0, 0, 1, 1, 3, 3, 0, 0, 1);
        send_shapes(1, 3, 3, 0, 0, 1, 1, 4, 3, 0, 0, 1);
        // Circle against rectangle: band, exact corner, corner miss, early reject.
        send_shapes(0, 1, 10, 9, 0, 1, 1, 0, 0, 2, 2, 1);
        send_shapes(0, 5, 6, 5, 0, 1, 1, 0, 0, 2, 2, 1);
        send_shapes(0, 5, 6, 4, 0, 1, 1, 0, 0, 2, 2, 1);
        send_shapes(0, 20, 0, 1, 0, 1, 1, 0, 0, 2, 2, 1);
        // Rectangle first, live flags that this test must ignore, point circles, extremes.
        send_shapes(1, 0, 0, 2, 2, 1, 0, 5, 6, 5, 0, 1);
        send_shapes(1, 0, 0, 2, 2, 0, 0, 1, 10, 9, 0, 0);
        send_shapes(0, 2, 2, 0, 0, 1, 1, 0, 0, 2, 2, 1);
        send_shapes(0, 1, 1, 0, 0, 1, 1, 0, 0, 2, 2, 1);
        send_shapes(0, -32768, -32768, 65535, 65535, 1, 1, 32767, 32767, 65535, 65535, 1);

        run_random_phase(643);
        wait_for_results();
        send_idle_pct = 54;
        recv_idle_pct = 26;
        run_random_phase(643);
        wait_for_results();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_phase(642);
        wait_for_results();
        repeat (8) @(negedge i_clk);

        $display("tb: checked %0d pairs: %0d circle-circle, %0d rectangle-rectangle, %0d mixed",
                 cc_count + rr_count + cr_count, cc_count, rr_count, cr_count);
        $display("tb: idling mixes 26/54, 54/26 and none, with a full drain after each");
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[filelist.f]
design/spot_pkg.sv
design/spot_prep.sv
design/spot_dist.sv
design/shape_pair_overlap_test_top.sv
test/spot_overlap_checker.sv
test/shape_pair_overlap_test_top_tb.sv
